/* rtl/core/ntc_pkg.sv */
// shared types, codes and constant tables for the ntc adc to temperature converter
package ntc_pkg;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RAIL  = 2'd1;
    localparam logic [1:0] ST_CLAMP = 2'd2;

    localparam int TEMP_W    = 16;
    localparam int STATUS_W  = 2;
    localparam int OFFSET_W  = 15;
    localparam int RES_W     = 16;
    localparam int TBL_SLOTS = 64;
    localparam int TBL_IDX_W = 6;
    localparam int STEP_W    = 6;
    localparam int PROD_W    = 25;
    localparam int FRAC_W    = 9;
    localparam int CALC_W    = 17;

    localparam logic [16:0] SCALE_K    = 17'd100000;
    localparam logic [31:0] DIV2_NUM   = 32'd1200000000;
    localparam logic [15:0] DIV2_HI    = DIV2_NUM[31:16];
    localparam logic [15:0] DIV2_LO    = DIV2_NUM[15:0];
    localparam logic [8:0]  STEP_CENTI = 9'd500;
    localparam logic [RES_W-1:0] RES_MAX = 16'hFFFF;

    localparam logic [STEP_W-1:0] DIV2_STEPS = 6'd16;
    localparam logic [STEP_W-1:0] DIV3_STEPS = 6'd9;

    // thermistor resistance in 10 ohm units, 0 degrees up in 5 degree steps
    localparam logic [RES_W-1:0] RES_TABLE [TBL_SLOTS] = '{
        0: 16'd34090, 1: 16'd26310, 2: 16'd20440, 3: 16'd16000, 4: 16'd12610,
        5: 16'd10000, 6: 16'd7981,  7: 16'd6408,  8: 16'd5174,  9: 16'd4202,
        10: 16'd3431, 11: 16'd2816, 12: 16'd2322, 13: 16'd1925, 14: 16'd1603,
        15: 16'd1340, 16: 16'd1126, 17: 16'd949,  18: 16'd804,  19: 16'd684,
        default: 16'd0
    };

    // command to the shared divider
    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } ntc_div_cmd_t;

endpackage

/* rtl/core/ntc_div.sv */
// shared restoring divider, one quotient bit per cycle
module ntc_div #(
    parameter int W = 27
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ntc_pkg::ntc_div_cmd_t cmd,
    input  logic [W-1:0]         rem_init,
    input  logic [W-1:0]         acc_init,
    input  logic [W-1:0]         den,
    output logic                 done,
    output logic [W-1:0]         quo
);
    import ntc_pkg::*;

    logic [W-1:0]      rem_reg, rem_next;
    logic [W-1:0]      acc_reg, acc_next;
    logic [W-1:0]      den_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              done_reg;
    logic [W:0]        trial;
    logic [W:0]        diff;

    // numerator bits leave at the top of acc, quotient bits enter at the bottom
    always_comb
    begin
        trial = {rem_reg, acc_reg[W-1]};
        diff  = trial - {1'b0, den_reg};
        if (!diff[W])
        begin
            rem_next = diff[W-1:0];
        end
        else
        begin
            rem_next = trial[W-1:0];
        end
        acc_next = {acc_reg[W-2:0], ~diff[W]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (cmd.start)
        begin
            cnt_reg  <= cmd.steps;
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            done_reg <= (cnt_reg == STEP_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            rem_reg <= rem_init;
            acc_reg <= acc_init;
            den_reg <= den;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= rem_next;
            acc_reg <= acc_next;
        end
    end

    assign done = done_reg;
    assign quo  = acc_reg;

endmodule

/* rtl/core/ntc_adc_to_temperature.sv */
// ntc adc sample to temperature converter: sequencer around one shared divider
//
//  channel | dir | handshake                 | payload
//  --------+-----+---------------------------+-------------------------------------
//  s_      | in  | s_tvalid / s_tready       | s_tdata: adc_sample
//  m_      | out | m_tvalid / m_tready       | m_tdata: temperature, m_tuser: status
//  cfg_    | in  | cfg_valid / cfg_ready     | cfg_data: temp_offset
//
// a sample runs division one, division two, the table scan, interpolation division and
// the final step; a rail sample goes straight to the final step. the shared divider
// retires one quotient bit per cycle and the table scan reads one entry per cycle.
// s_tready is high only while the sequencer is idle; a finished result waits in the
// output register, so a stalled m_ side holds only the final step. rst_n is async.
module ntc_adc_to_temperature #(
    parameter int TABLE_ENTRIES = 21,
    parameter int ADC_BITS      = 10
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [((ADC_BITS+7)/8)*8-1:0]  s_tdata,   // [ADC_BITS-1:0] adc_sample
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ntc_pkg::TEMP_W-1:0]     m_tdata,   // [15:0] temperature
    output logic [ntc_pkg::STATUS_W-1:0]   m_tuser,   // [1:0] status
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ntc_pkg::OFFSET_W-1:0]   cfg_data
);
    import ntc_pkg::*;

    localparam int QW = ADC_BITS + 17;
    localparam int IW = (TABLE_ENTRIES > 2) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [63:0] FULL64 = (64'd1 << ADC_BITS) - 64'd1;
    localparam logic [63:0] NUM1   = FULL64 * 64'd100000;
    localparam logic [ADC_BITS-1:0] FULL = FULL64[ADC_BITS-1:0];
    localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_DIV1, S_SUB, S_DIV2, S_SCAN, S_EVAL, S_MUL, S_DIV3, S_FIN
    } state_t;

    state_t                 state_reg;
    logic [OFFSET_W-1:0]    offset_reg;
    logic [RES_W-1:0]       r_reg;
    logic [IW-1:0]          idx_reg;
    logic [FRAC_W-1:0]      frac_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [STATUS_W-1:0]    status_reg;
    logic                   m_tvalid_reg;
    logic [TEMP_W-1:0]      m_tdata_reg;
    logic [STATUS_W-1:0]    m_tuser_reg;

    ntc_div_cmd_t           div_cmd;
    logic [QW-1:0]          div_rem_init;
    logic [QW-1:0]          div_acc_init;
    logic [QW-1:0]          div_den;
    logic                   div_done;
    logic [QW-1:0]          div_quo;

    logic [ADC_BITS-1:0]    sample;
    logic                   at_rail;
    logic [QW-1:0]          d_val;
    logic                   r_sat;
    logic [RES_W-1:0]       tbl_cur;
    logic [RES_W-1:0]       tbl_prev;
    logic [RES_W-1:0]       span;
    logic [RES_W-1:0]       above;
    logic [PROD_W-1:0]      prod;
    logic [CALC_W-1:0]      temp_calc;
    logic                   out_free;

    assign sample  = s_tdata[ADC_BITS-1:0];
    assign at_rail = (sample == '0) || (sample == FULL);
    assign d_val   = div_quo - QW'(SCALE_K);
    // quotient of the second division reaches 2^16 exactly when d is not above the top half
    assign r_sat   = (d_val <= QW'(DIV2_HI));

    assign tbl_cur  = RES_TABLE[TBL_IDX_W'(idx_reg)];
    assign tbl_prev = RES_TABLE[TBL_IDX_W'(idx_reg - 1'b1)];
    assign span     = tbl_prev - tbl_cur;
    assign above    = r_reg - tbl_cur;
    assign prod     = PROD_W'(above) * PROD_W'(STEP_CENTI);

    assign temp_calc = CALC_W'(idx_reg) * CALC_W'(STEP_CENTI)
                     - CALC_W'(frac_reg)
                     - {{(CALC_W-OFFSET_W){offset_reg[OFFSET_W-1]}}, offset_reg};

    assign out_free = !m_tvalid_reg || m_tready;

    // divider command mux
    always_comb
    begin
        div_cmd.start = 1'b0;
        div_cmd.steps = STEP_W'(QW);
        div_rem_init  = '0;
        div_acc_init  = NUM1[QW-1:0];
        div_den       = QW'(sample);
        case (state_reg)
            S_IDLE:
            begin
                div_cmd.start = s_tvalid && !at_rail;
            end
            S_SUB:
            begin
                div_cmd.start = !r_sat;
                div_cmd.steps = DIV2_STEPS;
                div_rem_init  = QW'(DIV2_HI);
                div_acc_init  = {DIV2_LO, {(QW-16){1'b0}}};
                div_den       = d_val;
            end
            S_MUL:
            begin
                div_cmd.start = (span != '0);
                div_cmd.steps = DIV3_STEPS;
                div_rem_init  = QW'(prod_reg[PROD_W-1:FRAC_W]);
                div_acc_init  = {prod_reg[FRAC_W-1:0], {(QW-FRAC_W){1'b0}}};
                div_den       = QW'(span);
            end
            default:
            begin
                div_cmd.start = 1'b0;
            end
        endcase
    end

    ntc_div #(
        .W (QW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (div_cmd),
        .rem_init (div_rem_init),
        .acc_init (div_acc_init),
        .den      (div_den),
        .done     (div_done),
        .quo      (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
        end
        else if (cfg_valid)
        begin
            offset_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            r_reg        <= '0;
            idx_reg      <= '0;
            frac_reg     <= '0;
            prod_reg     <= '0;
            status_reg   <= ST_OK;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= ST_OK;
        end
        else
        begin
            if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        idx_reg  <= '0;
                        frac_reg <= '0;
                        if (at_rail)
                        begin
                            status_reg <= ST_RAIL;
                            state_reg  <= S_FIN;
                        end
                        else
                        begin
                            status_reg <= ST_OK;
                            state_reg  <= S_DIV1;
                        end
                    end
                end
                S_DIV1:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_SUB;
                    end
                end
                S_SUB:
                begin
                    if (r_sat)
                    begin
                        r_reg     <= RES_MAX;
                        state_reg <= S_SCAN;
                    end
                    else
                    begin
                        state_reg <= S_DIV2;
                    end
                end
                S_DIV2:
                begin
                    if (div_done)
                    begin
                        r_reg     <= div_quo[RES_W-1:0];
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    // stop at the first entry not above r, or at the last entry
                    if ((idx_reg != LAST) && (tbl_cur > r_reg))
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    else
                    begin
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL:
                begin
                    if (idx_reg == '0)
                    begin
                        status_reg <= (r_reg > tbl_cur) ? ST_CLAMP : ST_OK;
                        state_reg  <= S_FIN;
                    end
                    else if (tbl_cur > r_reg)
                    begin
                        status_reg <= ST_CLAMP;
                        state_reg  <= S_FIN;
                    end
                    else
                    begin
                        prod_reg  <= prod;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    if (span != '0)
                    begin
                        state_reg <= S_DIV3;
                    end
                    else
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_DIV3:
                begin
                    if (div_done)
                    begin
                        frac_reg  <= div_quo[FRAC_W-1:0];
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= status_reg;
                        if (status_reg == ST_RAIL)
                        begin
                            m_tdata_reg <= '0;
                        end
                        else
                        begin
                            m_tdata_reg <= temp_calc[TEMP_W-1:0];
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

endmodule

/* rtl/core/ntc_chk.sv */
// port level checks for the ntc adc to temperature converter
module ntc_chk (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [ntc_pkg::TEMP_W-1:0]   m_tdata,
    input logic [ntc_pkg::STATUS_W-1:0] m_tuser
);
    import ntc_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // the converter is busy in the cycle after taking a sample
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("sample taken while still converting");

    // a rail sample reads zero
    a_rail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_RAIL) |-> (m_tdata == '0))
        else $error("rail status with nonzero temperature");

    // only the three defined status codes appear
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == ST_OK) || (m_tuser == ST_RAIL) || (m_tuser == ST_CLAMP))
        else $error("undefined status code");

endmodule

bind ntc_adc_to_temperature ntc_chk u_ntc_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
